FILE: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Types and fixed codes for the linear probing hash table core, including the
// entry layout of its slot memory.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int REQ_W     = 2;
	localparam int KEY_W     = 64;
	localparam int PAY_W     = 32;
	localparam int STATUS_W  = 2;
	localparam int SLOT_W    = 8;
	localparam int OCC_W     = 9;
	localparam int HASH_W    = 32;
	localparam int MARK_W    = 2;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

	localparam logic [MARK_W-1:0] MARK_EMPTY   = 2'd0;
	localparam logic [MARK_W-1:0] MARK_LIVE    = 2'd1;
	localparam logic [MARK_W-1:0] MARK_DELETED = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	localparam logic [HASH_W-1:0] HASH_MULT = 32'd37;

	typedef struct packed {
		logic [MARK_W-1:0] mark;
		logic [KEY_W-1:0]  key;
		logic [PAY_W-1:0]  value;
	} entry_t;

endpackage

FILE: rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
	parameter int WIDTH = 98,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open addressing hash table with linear probing and deleted marks. Each
// item is an insert, search or delete of a key of up to KEY_BYTES characters.
// ----------------------------------------------------------------------------
//  channel | handshake          | fields
//  --------+--------------------+--------------------------------------------
//  in      | in_valid, in_stall | req_type, key_chars, payload
//  out     | out_valid, out_stall | status, slot, found_payload, occupancy
//
// An item passes through an accept step, a hash step per key character plus a
// final one, remainder steps when TABLE_DEPTH is not a power of two, a slot
// memory read and check per probed slot, and a step that loads the result.
// After reset the slot memory is cleared, one slot a cycle, over all TABLE_DEPTH
// slots, and in_stall stays high meanwhile.
// A new item is taken while the previous result still waits on out_stall.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_BYTES   = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lpht_pkg::REQ_W-1:0]     req_type,
	input  logic [lpht_pkg::KEY_W-1:0]     key_chars,
	input  logic [lpht_pkg::PAY_W-1:0]     payload,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lpht_pkg::STATUS_W-1:0]  status,
	output logic [lpht_pkg::SLOT_W-1:0]    slot,
	output logic [lpht_pkg::PAY_W-1:0]     found_payload,
	output logic [lpht_pkg::OCC_W-1:0]     occupancy
);

	import lpht_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NW = $clog2(TABLE_DEPTH + 1);
	localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);
	localparam logic [HASH_W-1:0] DEPTH_H = HASH_W'(TABLE_DEPTH);
	localparam logic [HASH_W-1:0] RECIP   =
		HASH_W'(64'h1_0000_0000 / 64'(TABLE_DEPTH));

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLEAR = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_MOD   = 3'd3;
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_CHK   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	logic [2:0]          state_q;
	logic [REQ_W-1:0]    req_q;
	logic [KEY_W-1:0]    key_q;
	logic [KEY_W-1:0]    sh_q;
	logic [KEY_W-1:0]    bm_q;
	logic [PAY_W-1:0]    pay_q;
	logic [HASH_W-1:0]   h_q;
	logic [HASH_W-1:0]   quo_q;
	logic [3:0]          bi_q;
	logic [1:0]          mc_q;
	logic [AW-1:0]       idx_q;
	logic [NW-1:0]       n_q;
	logic [NW-1:0]       live_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [PAY_W-1:0]    res_found_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [PAY_W-1:0]    found_payload_q;
	logic [OCC_W-1:0]    occupancy_q;

	logic [KEY_W-1:0]    canon;
	logic [7:0]          ch;
	logic                hash_end;
	logic [HASH_W-1:0]   h_next;
	logic [2*HASH_W-1:0] recip_prod;
	logic [HASH_W-1:0]   back_prod;
	logic [AW-1:0]       rem_next;
	logic [AW-1:0]       idx_next;
	logic                probe_last;
	logic                ins_take;
	logic                key_hit;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	entry_t              ram_wdata;
	logic                ram_re;
	entry_t              ram_rdata;

	assign canon    = key_q & bm_q;
	assign ch       = sh_q[KEY_W-1 -: 8];
	assign hash_end = (bi_q == 4'(KEY_BYTES)) || (ch == 8'd0);
	assign h_next   = h_q * HASH_MULT + {24'd0, ch};
	assign recip_prod = (2*HASH_W)'(h_q) * (2*HASH_W)'(RECIP);
	assign back_prod  = quo_q * DEPTH_H;
	assign rem_next = (h_q >= DEPTH_H) ? AW'(h_q - DEPTH_H) : AW'(h_q);
	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign probe_last = (n_q == NW'(TABLE_DEPTH - 1));
	assign ins_take = (n_q == '0) ? (ram_rdata.mark != MARK_LIVE)
	                              : (ram_rdata.mark == MARK_EMPTY);
	assign key_hit  = (ram_rdata.mark == MARK_LIVE) && (ram_rdata.key == canon);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = '0;
		ram_re    = (state_q == S_RD);
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_CHK: begin
				if (req_q == REQ_INSERT && ins_take) begin
					ram_we          = 1'b1;
					ram_wdata.mark  = MARK_LIVE;
					ram_wdata.key   = canon;
					ram_wdata.value = pay_q;
				end else if (req_q == REQ_DELETE && key_hit) begin
					ram_we          = 1'b1;
					ram_wdata.mark  = MARK_DELETED;
					ram_wdata.key   = ram_rdata.key;
					ram_wdata.value = ram_rdata.value;
				end
			end
			default: begin
			end
		endcase
	end

	lpht_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			live_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					idx_q <= idx_next;
					if (idx_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						req_q        <= req_type;
						key_q        <= key_chars;
						sh_q         <= key_chars;
						pay_q        <= payload;
						bm_q         <= '0;
						h_q          <= '0;
						bi_q         <= '0;
						n_q          <= '0;
						res_status_q <= (req_type == REQ_INSERT && live_q == NW'(TABLE_DEPTH)) ?
							ST_FULL : ST_NOT_FOUND;
						res_slot_q   <= '0;
						res_found_q  <= '0;
						case (req_type)
							REQ_INSERT: begin
								if (live_q == NW'(TABLE_DEPTH)) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_HASH;
								end
							end
							REQ_SEARCH, REQ_DELETE: begin
								state_q <= S_HASH;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_HASH: begin
					if (hash_end) begin
						mc_q <= '0;
						if (IS_POW2) begin
							idx_q   <= h_q[AW-1:0];
							state_q <= S_RD;
						end else begin
							state_q <= S_MOD;
						end
					end else begin
						h_q  <= h_next;
						bm_q <= {8'hFF, bm_q[KEY_W-1:8]};
						sh_q <= {sh_q[KEY_W-9:0], 8'd0};
						bi_q <= bi_q + 4'd1;
					end
				end
				S_MOD: begin
					case (mc_q)
						2'd0: begin
							quo_q <= recip_prod[2*HASH_W-1:HASH_W];
							mc_q  <= 2'd1;
						end
						2'd1: begin
							h_q  <= h_q - back_prod;
							mc_q <= 2'd2;
						end
						default: begin
							idx_q   <= rem_next;
							state_q <= S_RD;
						end
					endcase
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (req_q == REQ_INSERT) begin
						if (ins_take) begin
							live_q       <= live_q + 1'b1;
							res_status_q <= ST_DONE;
							res_slot_q   <= SLOT_W'(idx_q);
							state_q      <= S_DONE;
						end else if (probe_last) begin
							res_status_q <= ST_FULL;
							state_q      <= S_DONE;
						end else begin
							idx_q   <= idx_next;
							n_q     <= n_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						if (ram_rdata.mark == MARK_EMPTY) begin
							res_status_q <= ST_NOT_FOUND;
							state_q      <= S_DONE;
						end else if (key_hit) begin
							res_status_q <= ST_DONE;
							res_slot_q   <= SLOT_W'(idx_q);
							res_found_q  <= ram_rdata.value;
							state_q      <= S_DONE;
							if (req_q == REQ_DELETE && live_q != '0) begin
								live_q <= live_q - 1'b1;
							end
						end else if (!probe_last) begin
							idx_q   <= idx_next;
							n_q     <= n_q + 1'b1;
							state_q <= S_RD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						status_q        <= res_status_q;
						slot_q          <= res_slot_q;
						found_payload_q <= res_found_q;
						occupancy_q     <= OCC_W'(live_q);
						out_valid_q     <= 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall      = (state_q != S_IDLE);
	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign slot          = slot_q;
	assign found_payload = found_payload_q;
	assign occupancy     = occupancy_q;

`ifndef SYNTH
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= NW'(TABLE_DEPTH))
		else $error("Live count exceeds the table depth.");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR || state_q == S_CHK))
		else $error("Slot memory written outside clearing or checking.");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("Result item raised outside the done state.");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK |-> n_q < NW'(TABLE_DEPTH))
		else $error("Probe ran past the table depth.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_DONE) |-> (slot_q == '0 && found_payload_q == '0))
		else $error("Failed item carries a slot or payload.");
`endif

endmodule
